// ===== sv/horizontal_box_blur_unit_assert.svh =====
// Assertion macros shared by the horizontal box blur unit
`ifndef HORIZONTAL_BOX_BLUR_UNIT_ASSERT_SVH
`define HORIZONTAL_BOX_BLUR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clk edge outside reset
`define HBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset
`define HBB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HBB_ASSERT(lbl, prop, msg)
`define HBB_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/hbb_pkg.sv =====
// Types and constants of the horizontal box blur unit
package hbb_pkg;

  localparam int MAX_RADIUS = 15;
  localparam int MAX_WIDTH  = 1024;
  localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;

  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  localparam int CH_W      = 8;
  localparam int QUO_W     = CH_W;
  localparam int CH_MAX    = (1 << CH_W) - 1;
  localparam int SUM_W     = $clog2(RING_DEPTH * CH_MAX + 1);
  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int DSH_W     = CNT_W + QUO_W - 1;
  localparam int TAP_W     = $clog2(RING_DEPTH);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RAD_W     = 4;
  localparam int DIV_STAGES = QUO_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [RAD_W-1:0]      RADIUS_RST    = RAD_W'(1);
  localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST = CFG_DATA_W'(320);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS    = 1'b0,
    CFG_ROW_WIDTH = 1'b1
  } cfg_reg_t;

  // Channel 2 is red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  // Beat handed along the divider chain
  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] rem;
    logic [DSH_W-1:0]             dsh;
    logic [NUM_CH-1:0][QUO_W-1:0] quo;
    logic                         row_done;
    logic                         burst_last;
  } div_data_t;

endpackage

// ===== sv/hbb_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit for all three channels
module hbb_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  hbb_pkg::div_data_t in_data,
  output logic               out_valid,
  output hbb_pkg::div_data_t out_data
);
  import hbb_pkg::*;

  logic      valid_r;
  div_data_t data_r;
  div_data_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (in_data.rem[ch] >= SUM_W'(in_data.dsh)) begin
        data_nxt.rem[ch] = in_data.rem[ch] - SUM_W'(in_data.dsh);
        data_nxt.quo[ch] = {in_data.quo[ch][QUO_W-2:0], 1'b1};
      end else begin
        data_nxt.quo[ch] = {in_data.quo[ch][QUO_W-2:0], 1'b0};
      end
    end
    data_nxt.dsh = in_data.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/hbb_pix_line.sv =====
// Pixel shift line with one selectable tap
module hbb_pix_line (
  input  logic                      clk,
  input  logic                      shift_en,
  input  hbb_pkg::pixel_t           pix_in,
  input  logic [hbb_pkg::TAP_W-1:0] tap_sel,
  output hbb_pkg::pixel_t           tap_out
);
  import hbb_pkg::*;

  pixel_t line_r [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (shift_en) begin
      line_r[0] <= pix_in;
      for (int i = 1; i < RING_DEPTH; i++) begin
        line_r[i] <= line_r[i-1];
      end
    end
  end

  assign tap_out = line_r[tap_sel];

endmodule

// ===== sv/horizontal_box_blur_unit.sv =====
// Horizontal box blur: running channel sums, pixel shift line, divider chain
//
// Input beats carry one RGB pixel each, row by row, rows of row_width pixels.
// Each output beat is the truncated per-channel average of the input pixels
// of the same row within radius columns of its own column; the window is
// clipped at both row ends. Output column x is produced by the input beat of
// column x + radius, and the last pixel of a row also flushes every pending
// output of that row, one per cycle while the output is not stalled, with
// input stalled while it does so. Throughput: one beat per cycle while the
// output is not stalled and no flush runs; the running sums and the
// eight-cell divider chain (one quotient bit per cell) allow this. A result
// passes through every cell register to out_valid. Stall on the output
// while a result is shown freezes the divider chain and stalls the input;
// the result already shown holds until taken. Reset (rst_n low at a clock
// edge) clears radius to 1, row_width to 320, the sums and both columns;
// it needs no clearing pass. A register write restarts the current row.
module horizontal_box_blur_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hbb_pkg::CH_W-1:0]       in_red_in,
  input  logic [hbb_pkg::CH_W-1:0]       in_green_in,
  input  logic [hbb_pkg::CH_W-1:0]       in_blue_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hbb_pkg::CH_W-1:0]       out_red_out,
  output logic [hbb_pkg::CH_W-1:0]       out_green_out,
  output logic [hbb_pkg::CH_W-1:0]       out_blue_out,
  output logic                           out_row_done,
  output logic                           out_burst_last
);
  import hbb_pkg::*;

`include "horizontal_box_blur_unit_assert.svh"

  // Configuration, kept as radius and (effective width - 1)
  logic [RAD_W-1:0] radius_r, radius_nxt;
  logic [COL_W-1:0] wm1_r, wm1_nxt;

  // Row state
  logic [COL_W-1:0]             in_col_r, in_col_nxt;
  logic [COL_W-1:0]             out_col_r, out_col_nxt;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_r, sum_nxt;
  logic                         flush_r, flush_nxt;

  // Front-end decode
  pixel_t           in_pix;
  pixel_t           line_tap;
  pixel_t           tap_pix;
  logic [TAP_W-1:0] tap_sel;
  logic             adv;
  logic             go_in;
  logic [COL_W-1:0] col;
  logic             last;
  logic [COL_W:0]   x_plus_b;
  logic             x_ge_b;
  logic             cond_in;
  logic             emit;
  logic             row_end;
  logic [COL_W-1:0] hi;
  logic [COL_W-1:0] lo;
  logic [COL_W-1:0] span;
  logic [CNT_W-1:0] cnt;
  logic [NUM_CH-1:0][SUM_W-1:0] sum_pre;
  div_data_t        issue_data;

  // Divider chain taps: stage 0 is the issue point, the last is the output
  logic      stage_valid [DIV_STAGES+1];
  div_data_t stage_data  [DIV_STAGES+1];

  assign in_pix = {in_red_in, in_green_in, in_blue_in};

  // Advance the chain whenever the output register is free or being taken
  assign adv      = !stage_valid[DIV_STAGES] || !out_stall;
  assign in_stall = flush_r || !adv;
  assign go_in    = in_valid && !in_stall;

  // Clamp the input column to the row, flag the row's last pixel
  assign col  = (in_col_r > wm1_r) ? wm1_r : in_col_r;
  assign last = (col == wm1_r);

  assign x_plus_b = {1'b0, out_col_r} + (COL_W+1)'(radius_r);
  assign x_ge_b   = (out_col_r >= COL_W'(radius_r));
  assign cond_in  = (out_col_r <= wm1_r) && (last || (x_plus_b <= {1'b0, col}));
  assign emit     = (go_in && cond_in) || (flush_r && adv);
  assign row_end  = emit && (out_col_r == wm1_r);

  // Clipped window bounds and pixel count
  assign hi   = (x_plus_b > {1'b0, wm1_r}) ? wm1_r : x_plus_b[COL_W-1:0];
  assign lo   = x_ge_b ? (out_col_r - COL_W'(radius_r)) : '0;
  assign span = hi - lo;
  assign cnt  = span[CNT_W-1:0] + CNT_W'(1);

  // The pixel leaving the window sits 2*radius back in the line, counted
  // before this cycle's shift; with zero radius it is the incoming pixel
  assign tap_sel = (radius_r == '0) ? '0 : (TAP_W'({radius_r, 1'b0}) - TAP_W'(1));
  assign tap_pix = (radius_r == '0) ? in_pix : line_tap;

  hbb_pix_line u_pix_line (
    .clk      (clk),
    .shift_en (go_in || (flush_r && adv)),
    .pix_in   (in_pix),
    .tap_sel  (tap_sel),
    .tap_out  (line_tap)
  );

  // Running sums: add the new pixel, drop the one leaving the window
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_pre[ch] = sum_r[ch] + (go_in ? SUM_W'(in_pix[ch]) : '0);
      if (cfg_we || row_end) begin
        sum_nxt[ch] = '0;
      end else if (emit && x_ge_b) begin
        sum_nxt[ch] = sum_pre[ch] - SUM_W'(tap_pix[ch]);
      end else begin
        sum_nxt[ch] = sum_pre[ch];
      end
    end
  end

  // Columns and flush flag
  always_comb begin
    if (cfg_we || row_end) begin
      out_col_nxt = '0;
    end else if (emit) begin
      out_col_nxt = out_col_r + COL_W'(1);
    end else begin
      out_col_nxt = out_col_r;
    end

    if (cfg_we) begin
      in_col_nxt = '0;
    end else if (go_in) begin
      in_col_nxt = last ? '0 : (col + COL_W'(1));
    end else begin
      in_col_nxt = in_col_r;
    end

    if (cfg_we || row_end) begin
      flush_nxt = 1'b0;
    end else if (go_in && last) begin
      flush_nxt = 1'b1;
    end else begin
      flush_nxt = flush_r;
    end
  end

  // Register writes; width is clamped to 1..MAX_WIDTH on the way in
  always_comb begin
    radius_nxt = radius_r;
    wm1_nxt    = wm1_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_RADIUS: begin
          radius_nxt = cfg_wdata[RAD_W-1:0];
        end
        CFG_ROW_WIDTH: begin
          if (cfg_wdata == '0) begin
            wm1_nxt = '0;
          end else if (cfg_wdata > CFG_DATA_W'(MAX_WIDTH)) begin
            wm1_nxt = COL_W'(MAX_WIDTH - 1);
          end else begin
            wm1_nxt = COL_W'(cfg_wdata - CFG_DATA_W'(1));
          end
        end
        default: begin
          radius_nxt = radius_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      wm1_r     <= COL_W'(ROW_WIDTH_RST - CFG_DATA_W'(1));
      in_col_r  <= '0;
      out_col_r <= '0;
      sum_r     <= '0;
      flush_r   <= 1'b0;
    end else begin
      radius_r  <= radius_nxt;
      wm1_r     <= wm1_nxt;
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      sum_r     <= sum_nxt;
      flush_r   <= flush_nxt;
    end
  end

  // Issue one beat into the divider chain per emitted output column
  always_comb begin
    issue_data.rem        = sum_pre;
    issue_data.dsh        = DSH_W'(cnt) << (QUO_W - 1);
    issue_data.quo        = '0;
    issue_data.row_done   = (out_col_r == wm1_r);
    issue_data.burst_last = (out_col_r == wm1_r) || (!flush_r && !last);
  end

  assign stage_valid[0] = emit;
  assign stage_data[0]  = issue_data;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    hbb_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (stage_valid[i]),
      .in_data   (stage_data[i]),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  // The last cell's register is the output register
  assign out_valid      = stage_valid[DIV_STAGES];
  assign out_red_out    = stage_data[DIV_STAGES].quo[CH_RED];
  assign out_green_out  = stage_data[DIV_STAGES].quo[CH_GREEN];
  assign out_blue_out   = stage_data[DIV_STAGES].quo[CH_BLUE];
  assign out_row_done   = stage_data[DIV_STAGES].row_done;
  assign out_burst_last = stage_data[DIV_STAGES].burst_last;

  `HBB_NEVER(a_in_col_in_row, in_col_r > wm1_r, "input column beyond row end")
  `HBB_NEVER(a_out_lags_in, !flush_r && (out_col_r > in_col_r), "output column ahead of input")
  `HBB_ASSERT(a_row_start_clean, (!flush_r && in_col_r == '0) |-> (sum_r == '0), "sums not cleared at row start")
  `HBB_ASSERT(a_flush_ends, (flush_r && adv && out_col_r == wm1_r) |=> !flush_r, "flush did not end at row end")

endmodule
